// File: src/point_segment_distance_assert.svh
// assertion macros shared by the point segment distance rtl
// expects clk and rst in the scope of each use
`ifndef POINT_SEGMENT_DISTANCE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_ASSERT_SVH

// same-cycle implication
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/psd_pkg.sv
// shared constants for the point segment distance block
// no dependencies
package psd_pkg;
  localparam int COORD_WIDTH_DEF = 24;
endpackage

// File: src/psd_ifs.sv
// request and result channels of the point segment distance block
// depends on psd_pkg for the default coordinate width
interface psd_in_if import psd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] seg_start_x;
  logic signed [W-1:0] seg_start_y;
  logic signed [W-1:0] seg_end_x;
  logic signed [W-1:0] seg_end_y;
  logic signed [W-1:0] query_x;
  logic signed [W-1:0] query_y;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  query_x, query_y, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                query_x, query_y, output ready);
endinterface

interface psd_out_if import psd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W:0]   distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

// File: src/psd_geom.sv
// geometry front end: differences, products, dot and cross sums, case select
// produces the radicand numerator and denominator; depends on psd_pkg
`include "point_segment_distance_assert.svh"

module psd_geom import psd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [W-1:0]  ax,
  input  logic signed [W-1:0]  ay,
  input  logic signed [W-1:0]  bx,
  input  logic signed [W-1:0]  by,
  input  logic signed [W-1:0]  cx,
  input  logic signed [W-1:0]  cy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4*W+1:0]       num,
  output logic [2*W:0]         den
);
  localparam int D   = W + 1;
  localparam int LW  = 2 * W + 1;
  localparam int DW  = 2 * D + 1;
  localparam int CRW = 2 * W + 1;
  localparam int NW  = 4 * W + 2;
  localparam int LOW = (CRW + 1) / 2;
  localparam int HIW = CRW - LOW;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s6_ready;

  // stage 1: differences
  logic signed [D-1:0] s1_dxb, s1_dyb, s1_dxc, s1_dyc, s1_dxe, s1_dye;
  // stage 2: products
  logic [2*W-1:0] s2_sq_xb, s2_sq_yb, s2_sq_xc, s2_sq_yc, s2_sq_xe, s2_sq_ye;
  logic signed [2*D-1:0] s2_pd1, s2_pd2, s2_pc1, s2_pc2;
  // stage 3: sums
  logic [LW-1:0] s3_len2, s3_da, s3_db;
  logic signed [DW-1:0] s3_dot, s3_cr;
  // stage 4: case select
  logic s4_perp;
  logic [CRW-1:0] s4_crmag;
  logic [LW-1:0] s4_small, s4_len2;
  // stage 5: partial squares
  logic s5_perp;
  logic [2*HIW-1:0] s5_hh;
  logic [HIW+LOW-1:0] s5_hl;
  logic [2*LOW-1:0] s5_ll;
  logic [LW-1:0] s5_small, s5_len2;
  // stage 6: radicand
  logic [NW-1:0] s6_num;
  logic [LW-1:0] s6_den;

  logic signed [2*D-1:0] m_xb, m_yb, m_xc, m_yc, m_xe, m_ye;
  logic signed [2*D-1:0] m_d1, m_d2, m_c1, m_c2;
  logic s3_degen, s3_perp;
  logic [DW-1:0] s3_crabs;
  logic [HIW-1:0] crhi;
  logic [LOW-1:0] crlo;
  logic [NW-1:0] crsq;

  assign s6_ready = !s6_valid || out_ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
      if (s6_ready) s6_valid <= s5_valid;
    end
  end

  always_comb begin
    m_xb = s1_dxb * s1_dxb;
    m_yb = s1_dyb * s1_dyb;
    m_xc = s1_dxc * s1_dxc;
    m_yc = s1_dyc * s1_dyc;
    m_xe = s1_dxe * s1_dxe;
    m_ye = s1_dye * s1_dye;
    m_d1 = s1_dxc * s1_dxb;
    m_d2 = s1_dyc * s1_dyb;
    m_c1 = s1_dxb * s1_dyc;
    m_c2 = s1_dyb * s1_dxc;
  end

  always_comb begin
    s3_degen = (s3_len2 == '0);
    s3_perp  = !s3_degen && !s3_dot[DW-1] && ($unsigned(s3_dot) <= DW'(s3_len2));
    s3_crabs = s3_cr[DW-1] ? DW'(-s3_cr) : DW'(s3_cr);
    crhi     = s4_crmag[CRW-1:LOW];
    crlo     = s4_crmag[LOW-1:0];
    crsq     = (NW'(s5_hh) << (2 * LOW)) + (NW'(s5_hl) << (LOW + 1)) + NW'(s5_ll);
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_dxb <= $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
      s1_dyb <= $signed({by[W-1], by}) - $signed({ay[W-1], ay});
      s1_dxc <= $signed({cx[W-1], cx}) - $signed({ax[W-1], ax});
      s1_dyc <= $signed({cy[W-1], cy}) - $signed({ay[W-1], ay});
      s1_dxe <= $signed({cx[W-1], cx}) - $signed({bx[W-1], bx});
      s1_dye <= $signed({cy[W-1], cy}) - $signed({by[W-1], by});
    end
    if (s2_ready && s1_valid) begin
      s2_sq_xb <= m_xb[2*W-1:0];
      s2_sq_yb <= m_yb[2*W-1:0];
      s2_sq_xc <= m_xc[2*W-1:0];
      s2_sq_yc <= m_yc[2*W-1:0];
      s2_sq_xe <= m_xe[2*W-1:0];
      s2_sq_ye <= m_ye[2*W-1:0];
      s2_pd1   <= m_d1;
      s2_pd2   <= m_d2;
      s2_pc1   <= m_c1;
      s2_pc2   <= m_c2;
    end
    if (s3_ready && s2_valid) begin
      s3_len2 <= LW'(s2_sq_xb) + LW'(s2_sq_yb);
      s3_da   <= LW'(s2_sq_xc) + LW'(s2_sq_yc);
      s3_db   <= LW'(s2_sq_xe) + LW'(s2_sq_ye);
      s3_dot  <= $signed({s2_pd1[2*D-1], s2_pd1}) + $signed({s2_pd2[2*D-1], s2_pd2});
      s3_cr   <= $signed({s2_pc1[2*D-1], s2_pc1}) - $signed({s2_pc2[2*D-1], s2_pc2});
    end
    if (s4_ready && s3_valid) begin
      s4_perp  <= s3_perp;
      s4_crmag <= s3_crabs[CRW-1:0];
      s4_len2  <= s3_len2;
      if (!s3_degen && (s3_db < s3_da)) begin
        s4_small <= s3_db;
      end else begin
        s4_small <= s3_da;
      end
    end
    if (s5_ready && s4_valid) begin
      s5_perp  <= s4_perp;
      s5_hh    <= (2*HIW)'(crhi) * (2*HIW)'(crhi);
      s5_hl    <= (HIW+LOW)'(crhi) * (HIW+LOW)'(crlo);
      s5_ll    <= (2*LOW)'(crlo) * (2*LOW)'(crlo);
      s5_small <= s4_small;
      s5_len2  <= s4_len2;
    end
    if (s6_ready && s5_valid) begin
      if (s5_perp) begin
        s6_num <= crsq;
        s6_den <= s5_len2;
      end else begin
        s6_num <= NW'(s5_small);
        s6_den <= LW'(1);
      end
    end
  end

  assign out_valid = s6_valid;
  assign num       = s6_num;
  assign den       = s6_den;

  `PSD_ASSERT_NEXT(a_degen_no_perp, s3_valid && s4_ready && s3_len2 == '0, !s4_perp, "perpendicular case taken on a degenerate segment")
  `PSD_ASSERT_NEXT(a_endpoint_den, s5_valid && s6_ready && !s5_perp, s6_den == LW'(1), "endpoint case with denominator other than one")
  `PSD_ASSERT_NOW(a_den_nonzero, s6_valid, s6_den != '0, "zero denominator leaves the front end")
endmodule

// File: src/psd_root_step.sv
// one bit of the ratio square root: tries bit B of q with q*q*den <= num
// keeps remainder and den*q so each step is a shift, add and compare; depends on psd_pkg
`include "point_segment_distance_assert.svh"

module psd_root_step import psd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF,
  parameter int B = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4*W+1:0]    rem_in,
  input  logic [3*W+1:0]    acc_in,
  input  logic [2*W:0]      den_in,
  input  logic [W:0]        q_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4*W+1:0]    rem_out,
  output logic [3*W+1:0]    acc_out,
  output logic [2*W:0]      den_out,
  output logic [W:0]        q_out
);
  localparam int NW = 4 * W + 2;
  localparam int SW = 3 * W + 2;
  localparam int TW = 4 * W + 4;

  logic [TW-1:0] term;
  logic          fit;

  assign term     = ((TW'({acc_in, 1'b0})) + (TW'(den_in) << B)) << B;
  assign fit      = (term <= TW'(rem_in));
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      den_out <= den_in;
      if (fit) begin
        rem_out  <= rem_in - term[NW-1:0];
        acc_out  <= acc_in + (SW'(den_in) << B);
        q_out    <= q_in | ((W+1)'(1) << B);
      end else begin
        rem_out  <= rem_in;
        acc_out  <= acc_in;
        q_out    <= q_in;
      end
    end
  end

  `PSD_ASSERT_NOW(a_low_bits_clear, in_valid, q_in[B:0] == '0, "lower root bits already set")
  `PSD_ASSERT_NEXT(a_bit_decision, in_valid && in_ready, q_out[B] == $past(fit), "root bit disagrees with trial")
  `PSD_ASSERT_NOW(a_den_kept, out_valid, den_out != '0, "zero denominator in root chain")
endmodule

// File: src/psd_root.sv
// pipelined ratio square root: W+1 restoring steps, one result bit per stage
// depends on psd_pkg and psd_root_step
module psd_root import psd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [4*W+1:0]  num,
  input  logic [2*W:0]    den,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [W:0]      q
);
  localparam int N = W + 1;

  logic            v   [N+1];
  logic            r   [N+1];
  logic [4*W+1:0]  rem [N+1];
  logic [3*W+1:0]  acc [N+1];
  logic [2*W:0]    dn  [N+1];
  logic [W:0]      qq  [N+1];

  assign v[0]    = in_valid;
  assign in_ready = r[0];
  assign rem[0]  = num;
  assign acc[0]  = '0;
  assign dn[0]   = den;
  assign qq[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_step
    psd_root_step #(.W(W), .B(W - i)) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[i]),
      .in_ready (r[i]),
      .rem_in   (rem[i]),
      .acc_in   (acc[i]),
      .den_in   (dn[i]),
      .q_in     (qq[i]),
      .out_valid(v[i+1]),
      .out_ready(r[i+1]),
      .rem_out  (rem[i+1]),
      .acc_out  (acc[i+1]),
      .den_out  (dn[i+1]),
      .q_out    (qq[i+1])
    );
  end

  assign r[N]      = out_ready;
  assign out_valid = v[N];
  assign q         = qq[N];
endmodule

// File: src/point_segment_distance.sv
// Least distance from a query point to a line segment, fixed point in and out, truncated
// toward zero. One request enters per clock and one result leaves per clock while the
// result side is ready; each request passes six front end stages for differences,
// products, sums and case select, then COORD_WIDTH + 1 square root stages that each
// settle one result bit. Stages advance independently, so a stalled result only blocks
// requests once the pipeline behind it is full.
// depends on psd_pkg, psd_ifs, psd_geom, psd_root
module point_segment_distance import psd_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  psd_in_if.sink      points,
  psd_out_if.source   result
);
  logic                       g_valid;
  logic                       g_ready;
  logic [4*COORD_WIDTH+1:0]   g_num;
  logic [2*COORD_WIDTH:0]     g_den;

  psd_geom #(.W(COORD_WIDTH)) u_geom (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_ready (points.ready),
    .ax       (points.seg_start_x),
    .ay       (points.seg_start_y),
    .bx       (points.seg_end_x),
    .by       (points.seg_end_y),
    .cx       (points.query_x),
    .cy       (points.query_y),
    .out_valid(g_valid),
    .out_ready(g_ready),
    .num      (g_num),
    .den      (g_den)
  );

  psd_root #(.W(COORD_WIDTH)) u_root (
    .clk      (clk),
    .rst      (rst),
    .in_valid (g_valid),
    .in_ready (g_ready),
    .num      (g_num),
    .den      (g_den),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .q        (result.distance)
  );
endmodule

// File: tb/sv/tb_point_segment_distance.sv
`timescale 1ns / 1ps
// testbench for point_segment_distance: directed table then random requests,
// each result checked against an exact integer model of the segment distance
// depends on psd_pkg, psd_ifs and the point_segment_distance rtl
module tb_point_segment_distance import psd_pkg::*;;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [31:0] NO_WANT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
    logic [31:0]          want;
  } seg_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   tx_idle = 0;
  int   rx_idle = 0;
  int   fail_cnt = 0;
  logic [CW:0] expected_dist[$];

  psd_in_if  #(.W(CW)) points_if ();
  psd_out_if #(.W(CW)) result_if ();

  point_segment_distance #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .points (points_if.sink),
    .result (result_if.source)
  );

  always #4 clk = ~clk;

  function automatic logic [CW:0] seg_distance(seg_req_t r);
    longint dxb, dyb, dxc, dyc, dxe, dye, len2, da, db, dot, cr;
    logic [159:0] num, den, t;
    logic [CW:0]  q;
    dxb = longint'(r.bx) - longint'(r.ax);
    dyb = longint'(r.by) - longint'(r.ay);
    dxc = longint'(r.cx) - longint'(r.ax);
    dyc = longint'(r.cy) - longint'(r.ay);
    dxe = longint'(r.cx) - longint'(r.bx);
    dye = longint'(r.cy) - longint'(r.by);
    len2 = dxb * dxb + dyb * dyb;
    da = dxc * dxc + dyc * dyc;
    den = 160'd1;
    if (len2 == 0) begin
      num = 160'(da);
    end else begin
      dot = dxc * dxb + dyc * dyb;
      if (dot >= 0 && dot <= len2) begin
        cr = dxb * dyc - dyb * dxc;
        if (cr < 0) cr = -cr;
        num = 160'(cr) * 160'(cr);
        den = 160'(len2);
      end else begin
        db = dxe * dxe + dye * dye;
        num = 160'((da <= db) ? da : db);
      end
    end
    q = '0;
    for (int b = CW; b >= 0; b--) begin
      t = 160'(q | ((CW+1)'(1) << b));
      if (t * t * den <= num) q = q | ((CW+1)'(1) << b);
    end
    return q;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(5))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] base);
    return base + CW'(int'($urandom_range(4095)) - 2048);
  endfunction

  function automatic seg_req_t random_req();
    seg_req_t r;
    logic signed [CW-1:0] base;
    r.want = NO_WANT;
    base = CW'($urandom);
    r.ax = near(base); r.ay = near(base);
    r.bx = near(base); r.by = near(base);
    r.cx = near(base); r.cy = near(base);
    case ($urandom_range(7))
      0: begin
        r.ax = CW'($urandom); r.ay = CW'($urandom); r.bx = CW'($urandom);
        r.by = CW'($urandom); r.cx = CW'($urandom); r.cy = CW'($urandom);
      end
      1: begin
        r.bx = r.ax; r.by = r.ay;
      end
      2: begin
        if ($urandom_range(1)) begin
          r.cx = r.ax; r.cy = r.ay;
        end else begin
          r.cx = r.bx; r.cy = r.by;
        end
      end
      3: begin
        r.ax = pick_coord(); r.ay = pick_coord(); r.bx = pick_coord();
        r.by = pick_coord(); r.cx = pick_coord(); r.cy = pick_coord();
      end
      4: begin
        // query on the perpendicular through an endpoint
        r.by = r.ay;
        r.cx = $urandom_range(1) ? r.ax : r.bx;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(seg_req_t r);
    while (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      points_if.valid <= 1'b0;
      @(posedge clk);
    end
    points_if.valid       <= 1'b1;
    points_if.seg_start_x <= r.ax;
    points_if.seg_start_y <= r.ay;
    points_if.seg_end_x   <= r.bx;
    points_if.seg_end_y   <= r.by;
    points_if.query_x     <= r.cx;
    points_if.query_y     <= r.cy;
    do @(posedge clk); while (!points_if.ready);
    if (r.want != NO_WANT) begin
      expected_dist.push_back((CW+1)'(r.want));
      if ((CW+1)'(r.want) != seg_distance(r)) begin
        $error("distance: expected %0d actual %0d", (CW+1)'(r.want), seg_distance(r));
        fail_cnt++;
      end
    end else begin
      expected_dist.push_back(seg_distance(r));
    end
  endtask

  always @(posedge clk) begin
    result_if.ready <= !rst && ($urandom_range(99) >= rx_idle);
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_dist.size() == 0) begin
        $error("distance: no request outstanding, actual %0d", result_if.distance);
        fail_cnt++;
      end else begin
        if (result_if.distance !== expected_dist[0]) begin
          $error("distance: expected %0d actual %0d", expected_dist[0], result_if.distance);
          fail_cnt++;
        end
        void'(expected_dist.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    seg_req_t dir_rows[$];
    dir_rows = '{
      '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 32'd0},
      '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd768, 24'sd1024, 32'd1280},
      '{24'sd0, 24'sd0, 24'sd2560, 24'sd0, 24'sd1280, 24'sd768, 32'd768},
      '{24'sd0, 24'sd0, 24'sd2560, 24'sd0, 24'sd1280, -24'sd768, 32'd768},
      '{24'sd0, 24'sd0, 24'sd256, 24'sd0, 24'sd1024, 24'sd1024, 32'd1280},
      '{24'sd0, 24'sd0, 24'sd256, 24'sd0, -24'sd768, -24'sd1024, 32'd1280},
      '{24'sd0, 24'sd0, 24'sd1024, 24'sd0, 24'sd0, 24'sd512, 32'd512},
      '{24'sd0, 24'sd0, 24'sd1024, 24'sd0, 24'sd1024, -24'sd512, 32'd512},
      '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 32'd0},
      '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 32'd0},
      '{CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, NO_WANT},
      '{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, NO_WANT},
      '{CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, NO_WANT},
      '{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, NO_WANT},
      '{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, NO_WANT},
      '{CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, NO_WANT},
      '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 32'd0},
      '{CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, 32'h00FF_FFFF},
      '{-24'sd1, -24'sd1, 24'sd1, 24'sd1, 24'sd5, -24'sd7, NO_WANT},
      '{24'sd3, 24'sd1, 24'sd3, 24'sd1, -24'sd300, 24'sd400, NO_WANT}
    };
    points_if.valid       = 1'b0;
    points_if.seg_start_x = '0;
    points_if.seg_start_y = '0;
    points_if.seg_end_x   = '0;
    points_if.seg_end_y   = '0;
    points_if.query_x     = '0;
    points_if.query_y     = '0;
    result_if.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send(dir_rows[i]);
    // hold off until the pipeline has drained
    points_if.valid <= 1'b0;
    wait (expected_dist.size() == 0);
    @(posedge clk);
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 27 : (ph == 1) ? 61 : 0;
      rx_idle = (ph == 0) ? 61 : (ph == 1) ? 27 : 0;
      for (int n = 0; n < 430; n++) send(random_req());
    end
    points_if.valid <= 1'b0;
    wait (expected_dist.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
